// ----- hdl/lane_split_montgomery_multiplier_core_defines.svh -----
// Assertion macros for the lane-split Montgomery multiplier.
// Included by the top level; relies on a clock named i_clk and reset i_rst_n.
`ifndef LANE_SPLIT_MONTGOMERY_MULTIPLIER_CORE_DEFINES_SVH
`define LANE_SPLIT_MONTGOMERY_MULTIPLIER_CORE_DEFINES_SVH

// Checked only while the block is out of reset.
`define LSMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSMM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/lsmm_pkg.sv -----
// Shared constants, types and register codes of the lane-split Montgomery multiplier.
// No dependencies; imported by every module of the block.
package lsmm_pkg;

    localparam int LANES      = 2;
    localparam int LANE_BITS  = 8;
    localparam int OP_BITS    = LANE_BITS - 2;
    localparam int WORD_BITS  = 16;
    localparam int SUM_BITS   = LANE_BITS - 1;
    // Lanes that overlap the word; lanes wholly above it never matter.
    localparam int USED_LANES = (LANES * LANE_BITS > WORD_BITS) ?
                                (WORD_BITS + LANE_BITS - 1) / LANE_BITS : LANES;
    localparam int PAD_BITS   = USED_LANES * LANE_BITS;
    // One cell per iteration: pre-pass then main pass.
    localparam int CELLS      = 2 * OP_BITS;
    localparam int MOD_BITS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS   = 2'd0,
        CFG_R_SQUARED = 2'd1,
        CFG_FULL      = 2'd2,
        CFG_REDUCE    = 2'd3
    } t_cfg_idx;

    typedef logic [SUM_BITS-1:0] t_sum;
    typedef logic [OP_BITS-1:0]  t_op;

    // Everything one cell hands to the next, for all lanes at once.
    typedef struct packed {
        t_sum [USED_LANES-1:0]   p;
        t_sum [USED_LANES-1:0]   q;
        t_op  [USED_LANES-1:0]   ap;
        t_op  [USED_LANES-1:0]   aq;
        logic [USED_LANES-1:0]   c;
        t_op  [USED_LANES-1:0]   bv;
        t_op  [USED_LANES-1:0]   keep_a;
        t_op  [USED_LANES-1:0]   keep_b;
    } t_cell;

endpackage

// ----- hdl/lsmm_cell.sv -----
// One Montgomery iteration for every lane, registered, with its own flow control.
// Depends on lsmm_pkg.
module lsmm_cell
    import lsmm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MOD_BITS-1:0] i_modulus,
    input  logic                i_valid,
    input  t_cell               i_data,
    output logic                o_ready,
    output logic                o_valid,
    output t_cell               o_data,
    input  logic                i_ready
);

    logic                  r_valid;
    t_cell                 r_data;
    t_cell                 n_data;
    logic [LANE_BITS-1:0]  w_mod;
    logic [LANE_BITS-1:0]  w_z1    [USED_LANES];
    logic [LANE_BITS-1:0]  w_s1    [USED_LANES];
    logic [LANE_BITS-1:0]  w_q1    [USED_LANES];
    logic [LANE_BITS-1:0]  w_z2    [USED_LANES];
    logic [LANE_BITS-1:0]  w_s2    [USED_LANES];
    logic [LANE_BITS-1:0]  w_cy2   [USED_LANES];
    logic [LANE_BITS-1:0]  w_cy1   [USED_LANES];
    logic [LANE_BITS-1:0]  w_p     [USED_LANES];
    logic [LANE_BITS-1:0]  w_q     [USED_LANES];
    logic                  w_abit  [USED_LANES];

    assign w_mod = LANE_BITS'(i_modulus);

    // Serial A bit, add B when set, add the modulus when odd, then halve.
    // Both adds stay in carry-save form and drop any carry out of the lane.
    always_comb begin
        n_data = i_data;
        for (int l = 0; l < USED_LANES; l++) begin
            w_p[l]    = LANE_BITS'(i_data.p[l]);
            w_q[l]    = LANE_BITS'(i_data.q[l]);
            w_abit[l] = i_data.ap[l][0] ^ i_data.aq[l][0] ^ i_data.c[l];
            n_data.c[l] = (i_data.ap[l][0] & i_data.aq[l][0]) |
                          (i_data.c[l] & (i_data.ap[l][0] ^ i_data.aq[l][0]));
            w_z1[l]  = w_abit[l] ? LANE_BITS'(i_data.bv[l]) : '0;
            w_s1[l]  = w_p[l] ^ w_q[l] ^ w_z1[l];
            w_cy1[l] = (w_p[l] & w_q[l]) | (w_p[l] & w_z1[l]) | (w_q[l] & w_z1[l]);
            w_q1[l]  = {w_cy1[l][LANE_BITS-2:0], 1'b0};
            w_z2[l]  = w_s1[l][0] ? w_mod : '0;
            w_s2[l]  = w_s1[l] ^ w_q1[l] ^ w_z2[l];
            w_cy2[l] = (w_s1[l] & w_q1[l]) | (w_s1[l] & w_z2[l]) | (w_q1[l] & w_z2[l]);
            n_data.p[l]  = w_s2[l][LANE_BITS-1:1];
            n_data.q[l]  = w_cy2[l][LANE_BITS-2:0];
            n_data.ap[l] = i_data.ap[l] >> 1;
            n_data.aq[l] = i_data.aq[l] >> 1;
        end
    end

    // A stage moves on when it is empty or its own beat is being taken.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/lsmm_out.sv -----
// Output stage: resolves the carry-save pair per lane, optional subtract, result register.
// Depends on lsmm_pkg.
module lsmm_out
    import lsmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [MOD_BITS-1:0]  i_modulus,
    input  logic                 i_reduce,
    input  logic                 i_valid,
    input  t_cell                i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_data,
    input  logic                 i_ready
);

    logic                  r_valid;
    logic [WORD_BITS-1:0]  r_data;
    logic [WORD_BITS-1:0]  n_data;
    logic [PAD_BITS-1:0]   w_pad;
    logic [LANE_BITS-1:0]  w_sum [USED_LANES];
    logic [LANE_BITS-1:0]  w_mod;

    assign w_mod = LANE_BITS'(i_modulus);

    // Lane result is P + Q modulo the lane, less the modulus once if asked.
    always_comb begin
        w_pad = '0;
        for (int l = 0; l < USED_LANES; l++) begin
            w_sum[l] = LANE_BITS'(i_data.p[l]) + LANE_BITS'(i_data.q[l]);
            if (i_reduce && (w_sum[l] >= w_mod)) begin
                w_sum[l] = w_sum[l] - w_mod;
            end
            w_pad[l*LANE_BITS +: LANE_BITS] = w_sum[l];
        end
        n_data = WORD_BITS'(w_pad);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/lane_split_montgomery_multiplier_core.sv -----
// Top level of the lane-split radix-2 Montgomery multiplier.
// Depends on lsmm_pkg, lsmm_cell, lsmm_out and the assertion macro header.
//
// The block takes one beat per clock unless held by back-pressure, and returns one result
// beat for each, in order, through a chain of 2*OP_BITS cells, one Montgomery iteration each
// (the first OP_BITS form the R^2 pre-pass of full mode), followed by the output register.
// Every stage has its own valid bit, so bubbles close up and a new beat is taken while a
// finished result waits at the output; input ready drops only when the whole chain is full
// and the output is stalled. Registers are written through the plain write port and must
// change only while no beat is in flight.
`include "lane_split_montgomery_multiplier_core_defines.svh"

module lane_split_montgomery_multiplier_core
    import lsmm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port.
    input  logic                    i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream: [15:0] a_lanes, [31:16] b_lanes.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [2*WORD_BITS-1:0]  s_axis_tdata,
    // Output stream: [15:0] product_lanes.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [WORD_BITS-1:0]    m_axis_tdata
);

    logic [MOD_BITS-1:0] r_modulus;
    logic [MOD_BITS-1:0] r_r_squared;
    logic                r_full;
    logic                r_reduce;

    logic                w_valid [CELLS+1];
    logic                w_ready [CELLS+1];
    t_cell               w_data  [CELLS+1];
    t_cell               w_entry;
    t_cell               w_join;
    logic [PAD_BITS-1:0] w_a_pad;
    logic [PAD_BITS-1:0] w_b_pad;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MOD_BITS'(15);
            r_r_squared <= MOD_BITS'(1);
            r_full      <= 1'b1;
            r_reduce    <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODULUS:   r_modulus   <= i_cfg_data[MOD_BITS-1:0];
                CFG_R_SQUARED: r_r_squared <= i_cfg_data[MOD_BITS-1:0];
                CFG_FULL:      r_full      <= i_cfg_data[0];
                CFG_REDUCE:    r_reduce    <= i_cfg_data[0];
                default:       r_full      <= r_full;
            endcase
        end
    end

    assign w_a_pad = PAD_BITS'(s_axis_tdata[WORD_BITS-1:0]);
    assign w_b_pad = PAD_BITS'(s_axis_tdata[2*WORD_BITS-1:WORD_BITS]);

    // Pre-pass entry: A = a, B = R^2 mod m; a and b ride along for the main pass.
    always_comb begin
        w_entry = '0;
        for (int l = 0; l < USED_LANES; l++) begin
            w_entry.keep_a[l] = w_a_pad[l*LANE_BITS +: OP_BITS];
            w_entry.keep_b[l] = w_b_pad[l*LANE_BITS +: OP_BITS];
            w_entry.ap[l]     = w_a_pad[l*LANE_BITS +: OP_BITS];
            w_entry.bv[l]     = OP_BITS'(r_r_squared);
        end
    end

    // Main-pass entry: A comes from the pre-pass pair in full mode, else straight from a.
    always_comb begin
        w_join = w_data[OP_BITS];
        for (int l = 0; l < USED_LANES; l++) begin
            w_join.p[l]  = '0;
            w_join.q[l]  = '0;
            w_join.c[l]  = 1'b0;
            w_join.bv[l] = w_data[OP_BITS].keep_b[l];
            w_join.ap[l] = r_full ? w_data[OP_BITS].p[l][OP_BITS-1:0]
                                  : w_data[OP_BITS].keep_a[l];
            w_join.aq[l] = r_full ? w_data[OP_BITS].q[l][OP_BITS-1:0] : '0;
        end
    end

    assign w_valid[0]    = s_axis_tvalid;
    assign w_data[0]     = w_entry;
    assign s_axis_tready = w_ready[0];

    // Chain of iteration cells.
    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        lsmm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_modulus (r_modulus),
            .i_valid   (w_valid[j]),
            .i_data    ((j == OP_BITS) ? w_join : w_data[j]),
            .o_ready   (w_ready[j]),
            .o_valid   (w_valid[j+1]),
            .o_data    (w_data[j+1]),
            .i_ready   (w_ready[j+1])
        );
    end

    lsmm_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_reduce  (r_reduce),
        .i_valid   (w_valid[CELLS]),
        .i_data    (w_data[CELLS]),
        .o_ready   (w_ready[CELLS]),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata),
        .i_ready   (m_axis_tready)
    );

    // Input back-pressure only ever comes from a full chain behind a held result.
    `LSMM_ASSERT(a_stall_needs_result, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result waiting")
    // An accepted beat always lands in the first cell.
    `LSMM_ASSERT(a_accept_lands, s_axis_tvalid && s_axis_tready |=> w_valid[1], "accepted beat lost at first cell")
    // Reset leaves no result pending.
    `LSMM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule
